// ===== hdl/tlc_pkg.sv =====
// Package for the trajectory limit checker: widths, reason codes, register
// addresses, limit constants and the configuration struct.
// No dependencies.
`default_nettype none
package tlc_pkg;
	localparam int MAX_POINTS = 4096;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IDX_W = 12;

	localparam logic [3:0] RC_OK    = 4'd0;
	localparam logic [3:0] RC_FEW   = 4'd1;
	localparam logic [3:0] RC_SPEED = 4'd2;
	localparam logic [3:0] RC_ACCEL = 4'd3;
	localparam logic [3:0] RC_CURV  = 4'd4;
	localparam logic [3:0] RC_STEP  = 4'd5;
	localparam logic [3:0] RC_KJUMP = 4'd6;
	localparam logic [3:0] RC_KRATE = 4'd7;
	localparam logic [3:0] RC_JERK  = 4'd8;

	localparam logic [2:0] REG_SPEED = 3'd0;
	localparam logic [2:0] REG_ACCEL = 3'd1;
	localparam logic [2:0] REG_CURV  = 3'd2;
	localparam logic [2:0] REG_JERK  = 3'd3;
	localparam logic [2:0] REG_MINPT = 3'd4;

	localparam logic [63:0] STEP_SQ_LIMIT = 64'd419430400;
	localparam logic [63:0] RATE_MIN_DEN  = 64'd65536;
	localparam logic [19:0] KAPPA_JUMP_LIMIT = 20'd81920;
	localparam logic [31:0] KAPPA_RATE_SCALE = 32'd640000;
	localparam logic [31:0] JERK_TIME_SCALE  = 32'd1000000;

	typedef struct packed {
		logic [14:0] speed_limit;
		logic [14:0] accel_limit;
		logic [18:0] curvature_limit;
		logic [15:0] jerk_limit;
		logic [12:0] min_point_count;
	} cfg_t;
endpackage
`default_nettype wire

// ===== hdl/tlc_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on tlc_pkg.
`default_nettype none
module tlc_mul
	import tlc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p_q
);
	// One product per cycle, registered.
	always_ff @(posedge clk) begin
		p_q <= {32'd0, a} * {32'd0, b};
	end
endmodule
`default_nettype wire

// ===== hdl/tlc_cfg.sv =====
// APB register file holding the five limit registers.
// Depends on tlc_pkg.
`default_nettype none
module tlc_cfg
	import tlc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output cfg_t             cfg
);
	logic [2:0] ridx;
	assign ridx = paddr[4:2];

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.speed_limit     <= 15'd12800;
			cfg.accel_limit     <= 15'd2560;
			cfg.curvature_limit <= 19'd4096;
			cfg.jerk_limit      <= 16'd5120;
			cfg.min_point_count <= 13'd2;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_SPEED: cfg.speed_limit     <= pwdata[14:0];
				REG_ACCEL: cfg.accel_limit     <= pwdata[14:0];
				REG_CURV:  cfg.curvature_limit <= pwdata[18:0];
				REG_JERK:  cfg.jerk_limit      <= pwdata[15:0];
				REG_MINPT: cfg.min_point_count <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		unique case (ridx)
			REG_SPEED: prdata = {17'd0, cfg.speed_limit};
			REG_ACCEL: prdata = {17'd0, cfg.accel_limit};
			REG_CURV:  prdata = {13'd0, cfg.curvature_limit};
			REG_JERK:  prdata = {16'd0, cfg.jerk_limit};
			REG_MINPT: prdata = {19'd0, cfg.min_point_count};
			default:   prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/tlc_core.sv =====
// Sequencer for the checks of one point, built around the shared multiplier.
// Depends on tlc_pkg and tlc_mul.
`default_nettype none
module tlc_core
	import tlc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [15:0] speed,
	input  wire logic        [31:0] time_us,
	input  wire logic signed [19:0] curvature,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_tangential,
	input  wire logic               last_point,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    valid_res,
	output logic             [3:0]  reason_code,
	output logic        [IDX_W-1:0] fail_index,
	output logic        [CNT_W-1:0] point_count
);
	// Sequencer states: each multiply step issues one product.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DX   = 3'd1;
	localparam logic [2:0] ST_DY   = 3'd2;
	localparam logic [2:0] ST_DK   = 3'd3;
	localparam logic [2:0] ST_KD   = 3'd4;
	localparam logic [2:0] ST_J1   = 3'd5;
	localparam logic [2:0] ST_J2   = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0] st_q;
	logic       phase_q;

	// Latched item.
	logic signed [31:0] px_q, py_q;
	logic        [31:0] t_q;
	logic signed [19:0] k_q;
	logic signed [15:0] at_q;
	logic               last_q;

	// Trajectory state.
	logic signed [31:0] prev_px_q, prev_py_q;
	logic signed [19:0] prev_k_q;
	logic        [31:0] prev_t_q, prev_dt_q;
	logic signed [15:0] prev_at_q;
	logic signed [16:0] prev_da_q;
	logic [CNT_W-1:0]   seen_q;
	logic [3:0]         pf_code_q, qf_code_q;
	logic [IDX_W-1:0]   pf_idx_q, qf_idx_q;
	logic               jerk_q;

	// Working values.
	logic [31:0] adx_q, ady_q;
	logic [19:0] adk_q;
	logic [63:0] d2_q;
	logic [63:0] lhs_q;
	logic [31:0] dt_q;
	logic [16:0] ada_q;
	logic        jhit_q;
	logic [3:0]  qcode_q;
	logic [IDX_W-1:0] idx_q;

	logic [31:0] ma, mb;
	logic [63:0] prod;

	tlc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(prod));

	// Helpers.
	function automatic logic [31:0] sat_abs_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		logic [32:0] m;
		d = {a[31], a} - {b[31], b};
		m = d[32] ? 33'(-d) : 33'(d);
		if (d > 33'sh0_7FFF_FFFF) sat_abs_diff = 32'h7FFF_FFFF;
		else if (d < -33'sh0_8000_0000) sat_abs_diff = 32'h8000_0000;
		else sat_abs_diff = m[31:0];
	endfunction

	function automatic logic [16:0] abs17(input logic signed [16:0] v);
		abs17 = v[16] ? 17'(-v) : v;
	endfunction

	// Per-point checks, evaluated on the incoming item at acceptance.
	logic [15:0] as_, aax, aay, aat;
	logic [19:0] ak;
	logic [3:0]  pcode;
	logic [IDX_W-1:0] idx_now;
	always_comb begin
		as_ = speed[15] ? 16'(-speed) : speed;
		aax = accel_x[15] ? 16'(-accel_x) : accel_x;
		aay = accel_y[15] ? 16'(-accel_y) : accel_y;
		aat = accel_tangential[15] ? 16'(-accel_tangential) : accel_tangential;
		ak  = curvature[19] ? 20'(-curvature) : curvature;
		pcode = RC_OK;
		if (as_ > {1'b0, cfg.speed_limit}) pcode = RC_SPEED;
		else if (aax > {1'b0, cfg.accel_limit} || aay > {1'b0, cfg.accel_limit}
				|| aat > {1'b0, cfg.accel_limit}) pcode = RC_ACCEL;
		else if (ak > {1'b0, cfg.curvature_limit}) pcode = RC_CURV;
		if (seen_q > CNT_W'(MAX_POINTS - 1)) idx_now = IDX_W'(MAX_POINTS - 1);
		else if (seen_q > CNT_W'(4095)) idx_now = IDX_W'(4095);
		else idx_now = IDX_W'(seen_q);
	end

	// Curvature difference, saturated to 20 bits.
	logic signed [20:0] dk;
	logic [19:0] adk;
	assign dk = {k_q[19], k_q} - {prev_k_q[19], prev_k_q};
	always_comb begin
		if (dk > 21'sd524287) adk = 20'd524287;
		else if (dk < -21'sd524288) adk = 20'd524288;
		else adk = dk[20] ? 20'(-dk) : dk[19:0];
	end

	logic signed [16:0] da;
	assign da = {at_q[15], at_q} - {prev_at_q[15], prev_at_q};

	// Multiplier operand select.
	always_comb begin
		ma = 32'd0;
		mb = 32'd0;
		unique case (st_q)
			ST_DX: begin ma = adx_q; mb = adx_q; end
			ST_DY: begin ma = ady_q; mb = ady_q; end
			ST_DK: begin ma = {12'd0, adk_q}; mb = {12'd0, adk_q}; end
			ST_KD: begin ma = {15'd0, ada_q}; mb = JERK_TIME_SCALE; end
			ST_J1: begin ma = {16'd0, cfg.jerk_limit}; mb = dt_q; end
			ST_J2: begin ma = {15'd0, abs17(prev_da_q)}; mb = JERK_TIME_SCALE; end
			ST_FIN: begin ma = {16'd0, cfg.jerk_limit}; mb = prev_dt_q; end
			default: ;
		endcase
	end

	assign in_ready = (st_q == ST_IDLE) && !out_valid;

	// Jerk over limit for one interval: |da|*1e6 > limit*dt, dt > 1.
	// Kappa-rate term compares dk^2 against 640000*d2 without a second product:
	// d2 < 2^63 fits, 640000*d2 is built by shifts and adds.
	logic [83:0] krate_rhs;
	assign krate_rhs = ({20'd0, d2_q} << 19) + ({20'd0, d2_q} << 17)
		- ({20'd0, d2_q} << 14) + ({20'd0, d2_q} << 10);

	// Jerk test over both intervals of the current triple, used in the last
	// sequencer cycle when prod holds limit*prev_dt and lhs_q holds |prev da|*1e6.
	logic jerk_now;
	assign jerk_now = (seen_q >= CNT_W'(2)) && (prev_dt_q > 32'd1) && (dt_q > 32'd1)
		&& (jhit_q || lhs_q > prod);

	// Point count including the current point.
	logic [CNT_W-1:0] cnt_fin;
	assign cnt_fin = (seen_q < CNT_W'(MAX_POINTS)) ? seen_q + CNT_W'(1) : seen_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			phase_q <= 1'b0;
			out_valid <= 1'b0;
			point_count <= '0;
			seen_q <= '0;
			pf_code_q <= RC_OK;
			qf_code_q <= RC_OK;
			pf_idx_q <= '0;
			qf_idx_q <= '0;
			jerk_q <= 1'b0;
			prev_px_q <= '0;
			prev_py_q <= '0;
			prev_k_q <= '0;
			prev_t_q <= '0;
			prev_dt_q <= '0;
			prev_at_q <= '0;
			prev_da_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						px_q <= pos_x;
						py_q <= pos_y;
						t_q <= time_us;
						k_q <= curvature;
						at_q <= accel_tangential;
						last_q <= last_point;
						idx_q <= idx_now;
						if (pcode != RC_OK && pf_code_q == RC_OK) begin
							pf_code_q <= pcode;
							pf_idx_q <= idx_now;
						end
						adx_q <= sat_abs_diff(pos_x, prev_px_q);
						ady_q <= sat_abs_diff(pos_y, prev_py_q);
						jhit_q <= 1'b0;
						st_q <= ST_DX;
					end
				end
				ST_DX: begin
					adk_q <= adk;
					ada_q <= abs17(da);
					dt_q <= (t_q >= prev_t_q) ? (t_q - prev_t_q) : 32'd0;
					st_q <= ST_DY;
				end
				ST_DY: begin
					d2_q <= prod;
					st_q <= ST_DK;
				end
				ST_DK: begin
					d2_q <= d2_q + prod;
					st_q <= ST_KD;
				end
				ST_KD: begin
					// prod = adk^2; d2 complete.
					if (d2_q > STEP_SQ_LIMIT) qcode_q <= RC_STEP;
					else if (adk_q > KAPPA_JUMP_LIMIT) qcode_q <= RC_KJUMP;
					else if ((d2_q * 25) > RATE_MIN_DEN && {20'd0, prod} > krate_rhs)
						qcode_q <= RC_KRATE;
					else qcode_q <= RC_OK;
					st_q <= ST_J1;
				end
				ST_J1: begin
					lhs_q <= prod; // |da|*1e6
					st_q <= ST_J2;
				end
				ST_J2: begin
					// prod = limit*dt.
					if (dt_q > 32'd1 && lhs_q > prod) jhit_q <= 1'b1;
					st_q <= ST_FIN;
					phase_q <= 1'b0;
				end
				ST_FIN: begin
					if (phase_q == 1'b0) begin
						// prod = |prev da|*1e6 while limit*prev_dt is being formed.
						lhs_q <= prod;
						phase_q <= 1'b1;
					end else begin
						st_q <= ST_IDLE;
						phase_q <= 1'b0;
						if (last_q) begin
							// Verdict goes out and the trajectory state clears.
							out_valid <= 1'b1;
							point_count <= cnt_fin;
							seen_q <= '0;
							pf_code_q <= RC_OK;
							qf_code_q <= RC_OK;
							pf_idx_q <= '0;
							qf_idx_q <= '0;
							jerk_q <= 1'b0;
							prev_px_q <= '0;
							prev_py_q <= '0;
							prev_k_q <= '0;
							prev_t_q <= '0;
							prev_dt_q <= '0;
							prev_at_q <= '0;
							prev_da_q <= '0;
						end else begin
							if (seen_q >= CNT_W'(1) && qcode_q != RC_OK
									&& qf_code_q == RC_OK) begin
								qf_code_q <= qcode_q;
								qf_idx_q <= idx_q;
							end
							if (jerk_now) jerk_q <= 1'b1;
							prev_px_q <= px_q;
							prev_py_q <= py_q;
							prev_k_q <= k_q;
							prev_t_q <= t_q;
							prev_at_q <= at_q;
							prev_dt_q <= (seen_q >= CNT_W'(1)) ? dt_q : 32'd0;
							prev_da_q <= (seen_q >= CNT_W'(1)) ? da : 17'sd0;
							seen_q <= cnt_fin;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Verdict, formed from the state as it stands in the last sequencer cycle.
	always_ff @(posedge clk) begin
		if (st_q == ST_FIN && phase_q == 1'b1 && last_q) begin
			if (cnt_fin < cfg.min_point_count) begin
				reason_code <= RC_FEW; fail_index <= '0;
			end else if (pf_code_q != RC_OK) begin
				reason_code <= pf_code_q; fail_index <= pf_idx_q;
			end else if (qf_code_q != RC_OK) begin
				reason_code <= qf_code_q; fail_index <= qf_idx_q;
			end else if (seen_q >= CNT_W'(1) && qcode_q != RC_OK) begin
				reason_code <= qcode_q; fail_index <= idx_q;
			end else if (jerk_q || jerk_now) begin
				reason_code <= RC_JERK; fail_index <= '0;
			end else begin
				reason_code <= RC_OK; fail_index <= '0;
			end
		end
	end
	assign valid_res = (reason_code == RC_OK);
endmodule
`default_nettype wire

// ===== hdl/trajectory_limit_checker.sv =====
// Trajectory limit checker: each point is checked in sequence on a single
// shared 32x32 multiplier stepped by a small sequencer, and the next point
// is accepted only once the sequencer is back in idle. The verdict is offered
// when the last point's sequence ends, and no point is accepted while it waits.
// Reset (arst_n low, asynchronous) clears trajectory state and loads the
// default limits.
`default_nettype none
module trajectory_limit_checker
	import tlc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic        [4:0]  paddr,
	input  wire logic        [31:0] pwdata,
	output logic             [31:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [15:0] speed,
	input  wire logic        [31:0] time_us,
	input  wire logic signed [19:0] curvature,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_tangential,
	input  wire logic               last_point,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    valid_res,
	output logic             [3:0]  reason_code,
	output logic        [IDX_W-1:0] fail_index,
	output logic        [CNT_W-1:0] point_count
);
	cfg_t cfg;
	assign pready = 1'b1;

	tlc_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .cfg);

	tlc_core u_core (.clk, .arst_n, .cfg, .in_valid, .in_ready, .pos_x, .pos_y,
		.speed, .time_us, .curvature, .accel_x, .accel_y, .accel_tangential,
		.last_point, .out_valid, .out_ready, .valid_res, .reason_code,
		.fail_index, .point_count);
endmodule
`default_nettype wire
